### hw/rtl/imu_fc_pkg.sv
// Package for the inertial-sensor frame checker.
// Holds frame constants, the status code type and the result struct.
// Used by imu_fc_frame and imu_frame_checker; depends on nothing.
`default_nettype none

package imu_fc_pkg;

  localparam logic [7:0] FrameHeader = 8'h55;
  localparam logic [7:0] TypeAngle   = 8'h53;
  localparam logic [7:0] TypeQuat    = 8'h59;
  localparam logic [3:0] SumLastIdx  = 4'd9;
  localparam logic [3:0] CheckIdx    = 4'd10;
  localparam logic [3:0] FrameLen    = 4'd11;
  localparam logic [3:0] PayloadBase = 4'd2;
  localparam int         PayloadLen  = 8;

  typedef enum logic [2:0] {
    ST_ANGLE   = 3'd0,
    ST_QUAT    = 3'd1,
    ST_OTHER   = 3'd2,
    ST_BADHEAD = 3'd3,
    ST_BADSUM  = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] value_c;
    logic [15:0] value_d;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/imu_fc_frame.sv
// Frame state of the checker: byte index, running sum, captured bytes.
// Decodes the status and payload words for the byte being stepped in.
// Depends on imu_fc_pkg.
`default_nettype none

module imu_fc_frame (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                burst_end,
  output imu_fc_pkg::result_t      result
);

  logic [3:0] byte_index;
  logic [7:0] running_sum;
  logic [7:0] header_byte;
  logic [7:0] type_byte;
  logic [7:0] payload_bytes [imu_fc_pkg::PayloadLen];
  logic [7:0] check_byte;

  logic [3:0] byte_index_next;
  logic [7:0] running_sum_next;
  logic [7:0] header_byte_next;
  logic [7:0] type_byte_next;
  logic [7:0] payload_bytes_next [imu_fc_pkg::PayloadLen];
  logic [7:0] check_byte_next;
  logic [3:0] slot;
  logic       in_frame;
  logic       words_on;

  assign in_frame = byte_index < imu_fc_pkg::FrameLen;
  assign slot     = byte_index - imu_fc_pkg::PayloadBase;

  always_comb begin
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    header_byte_next = header_byte;
    type_byte_next   = type_byte;
    check_byte_next  = check_byte;
    for (int i = 0; i < imu_fc_pkg::PayloadLen; i++) begin
      payload_bytes_next[i] = payload_bytes[i];
    end
    if (in_frame) begin
      byte_index_next = byte_index + 4'd1;
      if (byte_index == 4'd0) begin
        header_byte_next = rx_byte;
      end else if (byte_index == 4'd1) begin
        type_byte_next = rx_byte;
      end else if (byte_index <= imu_fc_pkg::SumLastIdx) begin
        payload_bytes_next[slot[2:0]] = rx_byte;
      end else begin
        check_byte_next = rx_byte;
      end
      if (byte_index <= imu_fc_pkg::SumLastIdx) begin
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  always_comb begin
    priority if (header_byte_next != imu_fc_pkg::FrameHeader) begin
      result.status = imu_fc_pkg::ST_BADHEAD;
    end else if (running_sum_next != check_byte_next) begin
      result.status = imu_fc_pkg::ST_BADSUM;
    end else if (type_byte_next == imu_fc_pkg::TypeAngle) begin
      result.status = imu_fc_pkg::ST_ANGLE;
    end else if (type_byte_next == imu_fc_pkg::TypeQuat) begin
      result.status = imu_fc_pkg::ST_QUAT;
    end else begin
      result.status = imu_fc_pkg::ST_OTHER;
    end
    words_on = (result.status == imu_fc_pkg::ST_ANGLE) ||
               (result.status == imu_fc_pkg::ST_QUAT);
    result.value_a = words_on ? {payload_bytes_next[1], payload_bytes_next[0]} : 16'd0;
    result.value_b = words_on ? {payload_bytes_next[3], payload_bytes_next[2]} : 16'd0;
    result.value_c = words_on ? {payload_bytes_next[5], payload_bytes_next[4]} : 16'd0;
    result.value_d = words_on ? {payload_bytes_next[7], payload_bytes_next[6]} : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && burst_end)) begin
      byte_index  <= 4'd0;
      running_sum <= 8'd0;
      header_byte <= 8'd0;
      type_byte   <= 8'd0;
      check_byte  <= 8'd0;
      for (int i = 0; i < imu_fc_pkg::PayloadLen; i++) begin
        payload_bytes[i] <= 8'd0;
      end
    end else if (step) begin
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      header_byte <= header_byte_next;
      type_byte   <= type_byte_next;
      check_byte  <= check_byte_next;
      for (int i = 0; i < imu_fc_pkg::PayloadLen; i++) begin
        payload_bytes[i] <= payload_bytes_next[i];
      end
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    byte_index <= imu_fc_pkg::FrameLen)
    else $error("byte index past frame length");

  a_clear_after_burst: assert property (@(posedge clk) disable iff (rst)
    step && burst_end |=> byte_index == 4'd0 && running_sum == 8'd0)
    else $error("frame state not cleared after burst end");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    step && !burst_end && in_frame |=> byte_index == $past(byte_index) + 4'd1)
    else $error("byte index did not advance");

  a_words_gated: assert property (@(posedge clk) disable iff (rst)
    !words_on |-> result.value_a == 16'd0 && result.value_d == 16'd0)
    else $error("payload words not zero for a non-data status");

endmodule

`default_nettype wire

### hw/rtl/imu_frame_checker.sv
// Top level of the inertial-sensor frame checker: input register, frame
// state and decode, result register. Depends on imu_fc_pkg, imu_fc_frame.
//
//   channel  signals                                    direction
//   in       in_valid, in_stall, rx_byte, burst_end     item in, one byte each
//   out      out_valid, out_stall, status, value_a..d   one item per burst end
//
// One byte item is taken every cycle while in_stall is low. The byte that
// carries burst_end goes through the input register, the frame decode and
// the result register, from which its result appears.
// Reset (rst, synchronous) empties both registers, clears the frame state and
// holds in_stall high.
// A stall on the output holds the result and raises in_stall in the same cycle.
`default_nettype none

module imu_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        burst_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      value_a,
  output logic [15:0]      value_b,
  output logic [15:0]      value_c,
  output logic [15:0]      value_d
);

  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_last;
  logic                advance;
  logic                step;
  imu_fc_pkg::result_t res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = rst || !advance;
  assign step     = advance && s1_valid;

  imu_fc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (s1_byte),
    .burst_end (s1_last),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_byte <= rx_byte;
      s1_last <= burst_end;
      if (s1_valid && s1_last) begin
        status  <= res.status;
        value_a <= res.value_a;
        value_b <= res.value_b;
        value_c <= res.value_c;
        value_d <= res.value_d;
      end
    end
  end

endmodule

`default_nettype wire

### dv/imu_frame_checker_test.sv
// Testbench for imu_frame_checker: directed bursts, then random frames with idle and stall.
// The table gives directed results, a byte-level decoder the random ones; a queue checks them.
// Depends on imu_fc_pkg and the imu_frame_checker RTL.
module imu_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import imu_fc_pkg::*;

  localparam int RandomItems = 1800;
  localparam int CycleLimit  = 400000;
  localparam int ShownErrors = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NoFrame = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        burst_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] value_a;
  logic [15:0] value_b;
  logic [15:0] value_c;
  logic [15:0] value_d;

  logic        row_typed = 1'b0;
  result_t     row_result = '0;

  logic [3:0]  f_index = '0;
  logic [7:0]  f_sum = '0;
  logic [7:0]  f_header = '0;
  logic [7:0]  f_type = '0;
  logic [7:0]  f_payload [PayloadLen] = '{default: 8'h00};
  logic [7:0]  f_check = '0;

  result_t     pending_frames [$];
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  stim_row_t directed [0:22] = '{
    '{8'hFF, 1'b1, 1'b1, '{ST_BADHEAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
    '{8'h55, 1'b0, 1'b0, NoFrame},
    '{8'hAB, 1'b1, 1'b0, NoFrame},
    '{8'h55, 1'b0, 1'b0, NoFrame},
    '{8'h53, 1'b0, 1'b0, NoFrame},
    '{8'h58, 1'b1, 1'b1, '{ST_ANGLE, 16'h0058, 16'h0000, 16'h0000, 16'h0000}},
    '{8'h55, 1'b0, 1'b0, NoFrame},
    '{8'h59, 1'b0, 1'b0, NoFrame},
    '{8'h52, 1'b1, 1'b1, '{ST_QUAT, 16'h0052, 16'h0000, 16'h0000, 16'h0000}},
    '{8'h55, 1'b1, 1'b1, '{ST_BADSUM, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
    '{8'h55, 1'b0, 1'b0, NoFrame},
    '{8'h59, 1'b0, 1'b0, NoFrame},
    '{8'hFF, 1'b0, 1'b0, NoFrame},
    '{8'hFF, 1'b0, 1'b0, NoFrame},
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'hFF, 1'b0, 1'b0, NoFrame},
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'h00, 1'b0, 1'b0, NoFrame},
    '{8'hFF, 1'b0, 1'b0, NoFrame},
    '{8'hAA, 1'b0, 1'b0, NoFrame},
    '{8'h3C, 1'b1, 1'b1, '{ST_QUAT, 16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00}},
    '{8'h00, 1'b1, 1'b1, '{ST_BADHEAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000}}
  };

  imu_frame_checker DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .burst_end (burst_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value_a   (value_a),
    .value_b   (value_b),
    .value_c   (value_c),
    .value_d   (value_d)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic take_byte(input logic [7:0] data, input logic last,
                           output logic done, output result_t res);
    status_t st;
    done = last;
    res = '0;
    if (f_index < FrameLen) begin
      if (f_index == 4'd0) begin
        f_header = data;
      end else if (f_index == 4'd1) begin
        f_type = data;
      end else if (f_index <= SumLastIdx) begin
        f_payload[f_index - PayloadBase] = data;
      end else begin
        f_check = data;
      end
      if (f_index <= SumLastIdx) begin
        f_sum = f_sum + data;
      end
      f_index = f_index + 4'd1;
    end
    if (last) begin
      if (f_header != FrameHeader) begin
        st = ST_BADHEAD;
      end else if (f_sum != f_check) begin
        st = ST_BADSUM;
      end else if (f_type == TypeAngle) begin
        st = ST_ANGLE;
      end else if (f_type == TypeQuat) begin
        st = ST_QUAT;
      end else begin
        st = ST_OTHER;
      end
      res.status = st;
      if (st == ST_ANGLE || st == ST_QUAT) begin
        res.value_a = {f_payload[1], f_payload[0]};
        res.value_b = {f_payload[3], f_payload[2]};
        res.value_c = {f_payload[5], f_payload[4]};
        res.value_d = {f_payload[7], f_payload[6]};
      end
      f_index = '0;
      f_sum = '0;
      f_header = '0;
      f_type = '0;
      f_payload = '{default: 8'h00};
      f_check = '0;
    end
  endtask

  always @(posedge clk) begin
    logic    done;
    result_t res;
    result_t got;
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        take_byte(rx_byte, burst_end, done, res);
        if (done) begin
          pending_frames.push_back(row_typed ? row_result : res);
        end
      end
      if (out_valid && !out_stall) begin
        got = {status, value_a, value_b, value_c, value_d};
        if (pending_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownErrors) begin
            $display("unexpected frame result: status %0d a %h b %h c %h d %h",
                     got.status, got.value_a, got.value_b, got.value_c, got.value_d);
          end
        end else begin
          want = pending_frames.pop_front();
          if (got.status !== want.status || got.value_a !== want.value_a ||
              got.value_b !== want.value_b || got.value_c !== want.value_c ||
              got.value_d !== want.value_d) begin
            mismatches++;
            if (mismatches <= ShownErrors) begin
              $display("frame result mismatch (expected/actual): status %0d/%0d a %h/%h b %h/%h",
                       want.status, got.status, want.value_a, got.value_a,
                       want.value_b, got.value_b);
              $display("  c %h/%h d %h/%h", want.value_c, got.value_c,
                       want.value_d, got.value_d);
            end
          end
        end
      end
    end
  end

  task automatic put_item(input logic [7:0] data, input logic last,
                          input logic typed, input result_t want);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= data;
    burst_end  <= last;
    row_typed  <= typed;
    row_result <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_frames();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_burst(output int count);
    logic [7:0] fb [$];
    logic [7:0] sum;
    int         pick;
    int         kind;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
    end else begin
      fb.push_back(pick < 11 ? 8'($urandom) : FrameHeader);
      kind = $urandom_range(0, 9);
      fb.push_back(kind < 4 ? TypeAngle : (kind < 8 ? TypeQuat : 8'($urandom)));
      repeat (PayloadLen) fb.push_back(8'($urandom));
      sum = '0;
      foreach (fb[i]) sum = sum + fb[i];
      fb.push_back(pick < 19 ? sum ^ 8'($urandom_range(1, 255)) : sum);
      if (pick >= 19 && pick < 29) begin
        fb = fb[0:$urandom_range(0, 9)];
      end else if (pick >= 29 && pick < 37) begin
        repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      in_calm = !in_calm;
    end
    foreach (fb[i]) begin
      put_item(fb[i], i == fb.size() - 1, 1'b0, NoFrame);
    end
    count = fb.size();
  endtask

  initial begin
    int hold;
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, 13);
      if (hold == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      if ($urandom_range(0, 9) == 0) begin
        out_calm = !out_calm;
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int  sent;
    int  count;
    bit  paused;
    sent = 0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      put_item(directed[i].data, directed[i].last, directed[i].typed, directed[i].want);
    end
    while (sent < RandomItems) begin
      send_random_burst(count);
      sent += count;
      if (!paused && sent >= RandomItems / 2) begin
        drain_frames();
        paused = 1'b1;
      end
    end
    drain_frames();
    repeat (8) @(posedge clk);
    if (pending_frames.size() != 0) begin
      $display("%0d frame results never arrived", pending_frames.size());
    end
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/imu_fc_pkg.sv
hw/rtl/imu_fc_frame.sv
hw/rtl/imu_frame_checker.sv
dv/imu_frame_checker_test.sv
